/* sv/bitvector_rank_select_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the rank/select unit checks.
// ----------------------------------------------------------------------------
`ifndef BITVECTOR_RANK_SELECT_UNIT_ASSERT_SVH
`define BITVECTOR_RANK_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BVRS_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("bvrs assertion failed");

// Next-cycle implication, disabled during reset.
`define BVRS_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("bvrs assertion failed");

`endif

/* sv/bvrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank/select unit package
// Payload types, request codes, controller states and shared helpers.
// ----------------------------------------------------------------------------
package bvrs_pkg;

    localparam int VECTOR_BITS_DEF = 1024;
    localparam int WORD_BITS       = 32;
    localparam int WORD_LSB        = 5;
    localparam int POS_W           = 11;
    localparam int TYPE_W          = 3;

    typedef enum logic [TYPE_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_RANK   = 3'd2,
        OP_SELECT = 3'd3,
        OP_NEXT   = 3'd4
    } req_op_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [POS_W-1:0]  position_or_count;
        logic              bit_value;
    } req_t;

    typedef struct packed {
        logic             bit_out;
        logic [POS_W-1:0] result_index;
        logic             error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EVAL,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic rd_en;
        logic addr_inc;
        logic clr_wr;
        logic wr_back;
        logic scan_step;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_op;
        logic last_addr;
        logic op_write;
        logic need_scan;
        logic scan_hit;
    } dp_status_t;

    function automatic logic [WORD_LSB:0] popcount32(input logic [WORD_BITS-1:0] w);
        logic [WORD_LSB:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + (WORD_LSB+1)'(w[i]);
        end
        return n;
    endfunction

endpackage

/* sv/bvrs_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// One word per cycle when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bvrs_chan_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/bvrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bvrs_ram
    import bvrs_pkg::*;
#(
    parameter int WIDTH = WORD_BITS,
    parameter int DEPTH = VECTOR_BITS_DEF / WORD_BITS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bvrs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank/select controller
// Sequences clear pass, word sweeps, write-back, bit scan and result hand-off.
// ----------------------------------------------------------------------------
`include "bitvector_rank_select_unit_assert.svh"

module bvrs_ctrl
    import bvrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t st
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                cmd.addr_inc = 1'b1;
                if (st.last_addr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (!st.sweep_op || st.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last word is folded in by the datapath this cycle
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (st.op_write)
                begin
                    state_next = ST_WRITE;
                end
                else if (st.need_scan)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_back = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_hit)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `BVRS_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_result, !out_valid_reg || out_ready)
    `BVRS_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.load_result, out_valid_reg)

endmodule

/* sv/bvrs_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank/select datapath
// Word store, per-word popcount and masking, hit capture and bit scan.
// ----------------------------------------------------------------------------
`include "bitvector_rank_select_unit_assert.svh"

module bvrs_dpath
    import bvrs_pkg::*;
#(
    parameter int VECTOR_BITS = VECTOR_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t st,
    output rsp_t       rsp_data
);

    localparam int WORDS = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(VECTOR_BITS + 1);
    localparam int IW    = (CW > POS_W) ? CW : POS_W;
    localparam int PW    = IW - WORD_LSB;
    localparam int RW    = WORD_LSB + 1;

    localparam logic [IW-1:0]        VB_IDX    = IW'(VECTOR_BITS);
    localparam logic [AW-1:0]        LAST_WORD = AW'(WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONE_W     = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] TWO_W     = WORD_BITS'(2);

    req_t                 req_reg, req_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 rd_valid_reg;
    logic [AW-1:0]        rd_w_reg;
    logic [IW-1:0]        acc_reg, acc_next;
    logic                 found_reg, found_next;
    logic [WORD_BITS-1:0] hit_word_reg, hit_word_next;
    logic [AW-1:0]        hit_w_reg, hit_w_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [WORD_LSB-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [IW-1:0]        sel_idx_reg, sel_idx_next;
    logic                 bit_reg, bit_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [IW-1:0]        pos_ext;
    logic [WORD_LSB-1:0]  pos_bit;
    logic [PW-1:0]        pos_word;
    logic [PW-1:0]        w_ext;
    logic [AW-1:0]        pos_addr;
    logic                 op_read, op_write, op_rank, op_select, op_next;
    logic                 pos_ge_len;
    logic                 k_zero;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] rank_mask, next_mask;
    logic [WORD_BITS-1:0] cnt_word, next_word;
    logic [RW-1:0]        pc;
    logic [IW-1:0]        sum;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, wb_word;

    assign pos_ext    = IW'(req_reg.position_or_count);
    assign pos_bit    = pos_ext[WORD_LSB-1:0];
    assign pos_word   = pos_ext[IW-1:WORD_LSB];
    assign pos_addr   = AW'(pos_word);
    assign w_ext      = PW'(rd_w_reg);
    assign pos_ge_len = (pos_ext >= VB_IDX);
    assign k_zero     = (pos_ext == '0);

    assign op_read   = (req_reg.req_type == OP_READ);
    assign op_write  = (req_reg.req_type == OP_WRITE);
    assign op_rank   = (req_reg.req_type == OP_RANK);
    assign op_select = (req_reg.req_type == OP_SELECT);
    assign op_next   = (req_reg.req_type == OP_NEXT);

    // Per-word masks against the operand position: bits below it, bits after it.
    always_comb
    begin
        if (w_ext < pos_word)
        begin
            rank_mask = '1;
            next_mask = '0;
        end
        else if (w_ext == pos_word)
        begin
            rank_mask = (ONE_W << pos_bit) - ONE_W;
            next_mask = ~((TWO_W << pos_bit) - ONE_W);
        end
        else
        begin
            rank_mask = '0;
            next_mask = '1;
        end
    end

    assign cnt_word  = op_rank ? (rd_word & rank_mask) : rd_word;
    assign next_word = rd_word & next_mask;
    assign pc        = popcount32(cnt_word);
    assign sum       = acc_reg + IW'(pc);

    // Word store: cleared by a sweep after reset, then read-modify-write.
    assign wb_word   = (hit_word_reg & ~(ONE_W << pos_bit))
                     | (WORD_BITS'(req_reg.bit_value) << pos_bit);
    assign ram_we    = cmd.clr_wr || (cmd.wr_back && !pos_ge_len);
    assign ram_waddr = cmd.clr_wr ? addr_reg : pos_addr;
    assign ram_wdata = cmd.clr_wr ? '0 : wb_word;
    assign ram_raddr = st.sweep_op ? addr_reg : pos_addr;

    bvrs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            addr_reg     <= addr_next;
            rd_valid_reg <= cmd.rd_en;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rd_w_reg     <= ram_raddr;
        acc_reg      <= acc_next;
        hit_word_reg <= hit_word_next;
        hit_w_reg    <= hit_w_next;
        rem_reg      <= rem_next;
        scan_cnt_reg <= scan_cnt_next;
        sel_idx_reg  <= sel_idx_next;
        bit_reg      <= bit_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        req_next      = req_reg;
        addr_next     = addr_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;
        hit_word_next = hit_word_reg;
        hit_w_next    = hit_w_reg;
        rem_next      = rem_reg;
        scan_cnt_next = scan_cnt_reg;
        sel_idx_next  = sel_idx_reg;
        bit_next      = bit_reg;

        if (cmd.start)
        begin
            req_next      = req_data;
            addr_next     = '0;
            acc_next      = '0;
            found_next    = 1'b0;
            scan_cnt_next = '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + AW'(1);
        end

        if (rd_valid_reg)
        begin
            unique case (req_reg.req_type)
                OP_READ:
                begin
                    bit_next = rd_word[pos_bit];
                end
                OP_WRITE:
                begin
                    hit_word_next = rd_word;
                end
                OP_RANK:
                begin
                    acc_next = sum;
                end
                OP_SELECT:
                begin
                    acc_next = sum;
                    // first word whose running count reaches k holds the k-th one
                    if (!found_reg && !k_zero && (sum >= pos_ext))
                    begin
                        found_next    = 1'b1;
                        hit_word_next = rd_word;
                        hit_w_next    = rd_w_reg;
                        rem_next      = RW'(pos_ext - acc_reg);
                    end
                end
                OP_NEXT:
                begin
                    if (!found_reg && (next_word != '0))
                    begin
                        found_next    = 1'b1;
                        hit_word_next = next_word;
                        hit_w_next    = rd_w_reg;
                        rem_next      = RW'(1);
                    end
                end
                default:
                begin
                    bit_next = 1'b0;
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            if (hit_word_reg[0] && (rem_reg == RW'(1)))
            begin
                sel_idx_next = IW'({hit_w_reg, scan_cnt_reg});
            end
            else if (hit_word_reg[0])
            begin
                rem_next = rem_reg - RW'(1);
            end
            hit_word_next = hit_word_reg >> 1;
            scan_cnt_next = scan_cnt_reg + WORD_LSB'(1);
        end
    end

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.load_result)
        begin
            rsp_next = '0;
            unique case (req_reg.req_type)
                OP_READ:
                begin
                    rsp_next.bit_out = bit_reg && !pos_ge_len;
                    rsp_next.error   = pos_ge_len;
                end
                OP_WRITE:
                begin
                    rsp_next.error = pos_ge_len;
                end
                OP_RANK:
                begin
                    rsp_next.result_index = acc_reg[POS_W-1:0];
                    rsp_next.error        = (pos_ext > VB_IDX);
                end
                OP_SELECT:
                begin
                    rsp_next.result_index = found_reg ? sel_idx_reg[POS_W-1:0]
                                                      : VB_IDX[POS_W-1:0];
                    rsp_next.error        = !found_reg;
                end
                OP_NEXT:
                begin
                    rsp_next.result_index = found_reg ? sel_idx_reg[POS_W-1:0]
                                                      : VB_IDX[POS_W-1:0];
                end
                default:
                begin
                    rsp_next.error = 1'b1;
                end
            endcase
        end
    end

    assign st.sweep_op  = op_rank || op_select || op_next;
    assign st.last_addr = (addr_reg == LAST_WORD);
    assign st.op_write  = op_write;
    assign st.need_scan = found_reg && (op_select || op_next);
    assign st.scan_hit  = hit_word_reg[0] && (rem_reg == RW'(1));

    assign rsp_data = rsp_reg;

    `BVRS_ASSERT_IMP(a_scan_has_ones, clk, rst_n, cmd.scan_step, hit_word_reg != '0)
    `BVRS_ASSERT_IMP(a_scan_rem_live, clk, rst_n, cmd.scan_step, rem_reg != '0)
    `BVRS_ASSERT_IMP(a_wb_write_only, clk, rst_n, cmd.wr_back, op_write && !op_read)

endmodule

/* sv/bitvector_rank_select_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit vector rank/select unit
// Holds a bit vector and serves read, write, rank, select and next-set-bit.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (req_type, position_or_count, bit_value);
//   rsp returns exactly one word per request (bit_out, result_index, error).
//   Requests are served one at a time; req.ready is high only while idle.
//   Vector is kept as WORDS = VECTOR_BITS/32 (rounded up) 32-bit RAM rows.
//   Work per request:
//     read, unknown type:         one RAM row read
//     write:                      read-modify-write of one row
//     rank:                       sweep of all rows (one row per cycle, popcount)
//     select, next set bit:       sweep of all rows, plus a bit scan of up to 32
//                                 bits over the row that holds the answer
//   The next request can be taken in the cycle after its result loads.
//   The single RAM read port walking one row per cycle sets the sweep length.
//   After reset the unit clears every RAM row with req.ready low.
//   A finished result sits in the output register; if rsp stalls, the unit
//   still takes the next request and holds its result until rsp drains.
// ----------------------------------------------------------------------------
module bitvector_rank_select_unit
    import bvrs_pkg::*;
#(
    parameter int VECTOR_BITS = VECTOR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    bvrs_chan_if.sink   req,
    bvrs_chan_if.source rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    bvrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .st        (st)
    );

    bvrs_dpath #(
        .VECTOR_BITS (VECTOR_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .st       (st),
        .rsp_data (rsp.data)
    );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rank/select unit testbench
// Drives read, write, rank, select, next-set-bit and unknown-type requests through the
// valid/ready channels with random gaps and stalls. A scoreboard keeps its own
// copy of the bit vector and checks each response word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import bvrs_pkg::*;

    localparam int VB            = VECTOR_BITS_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STEADY_FIRST  = 700;
    localparam int STEADY_LAST   = 1000;
    localparam int PHASE_ITEMS   = 456;
    localparam int MAX_REPORTS   = 10;

    localparam logic [TYPE_W-1:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [TYPE_W-1:0] OP_LAST_CODE    = 3'd7;

    // ------------------------------------------------------------------
    // Scoreboard: shadow bit vector plus a queue of expected words
    // ------------------------------------------------------------------
    class bvrs_scoreboard;
        localparam int CELLS = VECTOR_BITS_DEF;

        typedef struct {
            req_t req;
            rsp_t rsp;
        } expected_word_t;

        bit [CELLS-1:0]  cells;
        int unsigned     ones_now;
        int unsigned     peak_ones;
        expected_word_t  pending[$];
        int unsigned     checked;
        int unsigned     mismatches;
        int unsigned     flagged;
        int unsigned     op_seen[8];

        function int unsigned ones_below(int unsigned limit);
            int unsigned n;
            int unsigned j;
            n = 0;
            if (limit > CELLS)
                limit = CELLS;
            for (j = 0; j < limit; j++)
                n += cells[j];
            return n;
        endfunction

        function void note_request(req_t r);
            expected_word_t e;
            int unsigned    p;
            int unsigned    hits;
            int unsigned    j;
            e.req = r;
            e.rsp = '0;
            p = r.position_or_count;
            op_seen[r.req_type]++;
            case (r.req_type)
                OP_READ:
                begin
                    if (p < CELLS)
                        e.rsp.bit_out = cells[p];
                    else
                        e.rsp.error = 1'b1;
                end
                OP_WRITE:
                begin
                    if (p < CELLS)
                    begin
                        if (cells[p] != r.bit_value)
                        begin
                            if (r.bit_value)
                                ones_now++;
                            else
                                ones_now--;
                        end
                        cells[p] = r.bit_value;
                        if (ones_now > peak_ones)
                            peak_ones = ones_now;
                    end
                    else
                        e.rsp.error = 1'b1;
                end
                OP_RANK:
                begin
                    // past the end: flag it and saturate to the full count
                    e.rsp.error        = (p > CELLS);
                    e.rsp.result_index = POS_W'(ones_below(p));
                end
                OP_SELECT:
                begin
                    e.rsp.result_index = POS_W'(CELLS);
                    if (p == 0 || p > ones_now)
                        e.rsp.error = 1'b1;
                    else
                    begin
                        hits = 0;
                        for (j = 0; j < CELLS; j++)
                        begin
                            hits += cells[j];
                            if (hits == p)
                            begin
                                e.rsp.result_index = POS_W'(j);
                                break;
                            end
                        end
                    end
                end
                OP_NEXT:
                begin
                    e.rsp.result_index = POS_W'(CELLS);
                    for (j = p + 1; j < CELLS; j++)
                    begin
                        if (cells[j])
                        begin
                            e.rsp.result_index = POS_W'(j);
                            break;
                        end
                    end
                end
                default:
                    e.rsp.error = 1'b1;
            endcase
            if (e.rsp.error)
                flagged++;
            pending.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            expected_word_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch %0d: response with nothing expected: bit %0b idx %0d err %0b",
                             mismatches, got.bit_out, got.result_index, got.error);
                return;
            end
            e = pending.pop_front();
            if (got.bit_out !== e.rsp.bit_out || got.result_index !== e.rsp.result_index ||
                got.error !== e.rsp.error)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch %0d: type %0d operand %0d value %0b: ",
                              "expected bit %0b idx %0d err %0b, got bit %0b idx %0d err %0b"},
                             mismatches, e.req.req_type, e.req.position_or_count,
                             e.req.bit_value, e.rsp.bit_out, e.rsp.result_index, e.rsp.error,
                             got.bit_out, got.result_index, got.error);
            end
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count;
    int unsigned random_sent;
    bit          hold_done;

    bvrs_chan_if #(.data_t(req_t)) req_if ();
    bvrs_chan_if #(.data_t(rsp_t)) rsp_if ();

    bvrs_scoreboard sb;

    bitvector_rank_select_unit #(
        .VECTOR_BITS (VB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Check the finished word first, then note the new request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.data);
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.data);
        end
    end

    // Response side: random stalls, one long hold-off, one steady stretch
    initial
    begin : rsp_sink
        int unsigned taken;
        int unsigned hold_left;
        taken     = 0;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                taken++;
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (taken == HOLD_AT && !hold_done)
            begin
                // hold off long enough for the unit to fill and block requests
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else if (taken >= STEADY_FIRST && taken < STEADY_LAST)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(99) >= 25);
        end
    end

    // Offer one word and hold it until accepted; valid stays high across items unless a random gap drops it
    task automatic send_request(input req_t r);
        bit steady;
        steady = (random_sent >= STEADY_FIRST && random_sent < STEADY_LAST);
        while (!steady && $urandom_range(99) < 25)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic send_op(input logic [TYPE_W-1:0] op, input int unsigned operand,
                           input bit value);
        req_t r;
        r.req_type          = op;
        r.position_or_count = POS_W'(operand);
        r.bit_value         = value;
        send_request(r);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(9))
            0:       return POS_W'($urandom_range(VB - 1, VB - 24));
            1:       return POS_W'($urandom_range(23));
            default: return POS_W'($urandom_range(VB - 1));
        endcase
    endfunction

    // Mostly well-formed requests; a few percent are out of range or unknown
    task automatic send_random(input int unsigned set_pct);
        req_t        r;
        int unsigned roll;
        int unsigned ones;
        roll = $urandom_range(99);
        ones = sb.ones_now;
        r.position_or_count = pick_position();
        r.bit_value         = 1'($urandom_range(1));
        if (roll < 35)
        begin
            r.req_type  = OP_WRITE;
            r.bit_value = ($urandom_range(99) < set_pct);
        end
        else if (roll < 50)
            r.req_type = OP_READ;
        else if (roll < 63)
        begin
            r.req_type = OP_RANK;
            if ($urandom_range(3) == 0)
                r.position_or_count = POS_W'($urandom_range(VB));
        end
        else if (roll < 80)
        begin
            r.req_type          = OP_SELECT;
            r.position_or_count = POS_W'((ones == 0) ? 1 : $urandom_range(ones, 1));
        end
        else if (roll < 93)
            r.req_type = OP_NEXT;
        else
        begin
            case ($urandom_range(3))
                0:
                    r.req_type = TYPE_W'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
                1:
                begin
                    r.req_type          = TYPE_W'($urandom_range(OP_NEXT, OP_READ));
                    r.position_or_count = POS_W'($urandom_range((1 << POS_W) - 1, VB));
                end
                2:
                begin
                    r.req_type          = OP_SELECT;
                    r.position_or_count = POS_W'($urandom_range((1 << POS_W) - 1, ones + 1));
                end
                default:
                begin
                    r.req_type          = OP_SELECT;
                    r.position_or_count = '0;
                end
            endcase
        end
        send_request(r);
        random_sent++;
    endtask

    initial
    begin : stimulus
        int unsigned set_pct[4];
        int unsigned ph;
        int unsigned i;
        logic [TYPE_W-1:0] t;
        set_pct = '{85, 50, 15, 70};
        sb = new();
        random_sent = 0;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty vector: ends, out-of-range reads and writes
        send_op(OP_READ, 0, 1'b0);
        send_op(OP_READ, VB - 1, 1'b1);
        send_op(OP_NEXT, 0, 1'b0);
        send_op(OP_SELECT, 1, 1'b0);
        send_op(OP_READ, VB, 1'b0);
        send_op(OP_WRITE, VB, 1'b1);
        send_op(OP_WRITE, (1 << POS_W) - 1, 1'b1);
        send_op(OP_READ, (1 << POS_W) - 1, 1'b0);
        // set both ends, then query around them
        send_op(OP_WRITE, 0, 1'b1);
        send_op(OP_WRITE, VB - 1, 1'b1);
        send_op(OP_READ, VB - 1, 1'b0);
        send_op(OP_RANK, 0, 1'b0);
        send_op(OP_RANK, VB, 1'b1);
        send_op(OP_RANK, VB + 1, 1'b0);
        send_op(OP_RANK, (1 << POS_W) - 1, 1'b0);
        send_op(OP_SELECT, 0, 1'b0);
        send_op(OP_SELECT, 1, 1'b1);
        send_op(OP_SELECT, 2, 1'b0);
        send_op(OP_SELECT, 3, 1'b0);
        send_op(OP_SELECT, (1 << POS_W) - 1, 1'b0);
        send_op(OP_NEXT, 0, 1'b0);
        send_op(OP_NEXT, VB - 1, 1'b0);
        send_op(OP_NEXT, (1 << POS_W) - 1, 1'b1);
        for (t = OP_FIRST_UNUSED; t != OP_READ; t++)
            send_op(t, $urandom_range((1 << POS_W) - 1), 1'b1);
        send_op(OP_WRITE, 0, 1'b0);

        // density phases: fill, churn, thin out, refill
        for (ph = 0; ph < 4; ph++)
            for (i = 0; i < PHASE_ITEMS; i++)
                send_random(set_pct[ph]);
        req_if.valid <= 1'b0;

        // let the monitor note the last accepted word before draining
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: read %0d write %0d rank %0d select %0d next %0d unknown %0d",
                 sb.op_seen[OP_READ], sb.op_seen[OP_WRITE], sb.op_seen[OP_RANK],
                 sb.op_seen[OP_SELECT], sb.op_seen[OP_NEXT],
                 sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7]);
        $display("responses checked %0d, error words %0d, peak ones %0d, mismatches %0d",
                 sb.checked, sb.flagged, sb.peak_ones, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
